// ===== src/c_token_scanner_top_assert.svh =====
// assertion macros for the token scanner
`ifndef C_TOKEN_SCANNER_TOP_ASSERT_SVH
`define C_TOKEN_SCANNER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CTS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CTS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define CTS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== src/cts_pkg.sv =====
package cts_pkg;

    localparam int OFFSET_BITS_DEF   = 16;
    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int MAX_TOKENS        = 4;

    localparam logic [5:0] K_IDENT   = 6'd0;
    localparam logic [5:0] K_NUM     = 6'd24;
    localparam logic [5:0] K_CHARLIT = 6'd25;
    localparam logic [5:0] K_STRLIT  = 6'd26;
    localparam logic [5:0] K_DOT     = 6'd35;
    localparam logic [5:0] K_END     = 6'd56;
    localparam logic [5:0] K_ERROR   = 6'd57;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_CHAR, M_STR, M_OP,
        M_LINE, M_BLOCK, M_BSTAR
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] offset;
        logic [15:0] length;
    } token_t;

    typedef struct packed {
        logic [2:0]             count;
        token_t [MAX_TOKENS-1:0] tok;
    } token_group_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [5:0] single_op(input logic [7:0] h);
        logic [5:0] k;
        unique case (h)
            "*": k = 6'd37;
            "/": k = 6'd39;
            "+": k = 6'd41;
            "-": k = 6'd44;
            ">": k = 6'd48;
            "<": k = 6'd50;
            "=": k = 6'd52;
            "!": k = 6'd54;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] pair_op(input logic [7:0] h, input logic [7:0] c);
        logic [5:0] k;
        k = 6'd0;
        if (c == "=") begin
            unique case (h)
                "*": k = 6'd38;
                "/": k = 6'd40;
                "+": k = 6'd42;
                "-": k = 6'd45;
                ">": k = 6'd49;
                "<": k = 6'd51;
                "=": k = 6'd53;
                "!": k = 6'd55;
                default: k = 6'd0;
            endcase
        end else if (h == "+" && c == "+") begin
            k = 6'd43;
        end else if (h == "-" && c == "-") begin
            k = 6'd46;
        end else if (h == "-" && c == ">") begin
            k = 6'd47;
        end
        return k;
    endfunction

    function automatic logic [5:0] punct(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            "{": k = 6'd27;
            "}": k = 6'd28;
            "[": k = 6'd29;
            "]": k = 6'd30;
            "(": k = 6'd31;
            ")": k = 6'd32;
            "#": k = 6'd33;
            ",": k = 6'd34;
            ".": k = 6'd35;
            ";": k = 6'd36;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    // keyword lookup on the first eight buffered chars, char 0 in low byte
    function automatic logic [5:0] keyword(input logic [63:0] w, input logic [3:0] n);
        logic [5:0] k;
        k = K_IDENT;
        unique case ({n, w})
            {4'd4, 32'd0, "loob"}:      k = 6'd1;
            {4'd5, 24'd0, "kaerb"}:     k = 6'd2;
            {4'd4, 32'd0, "esac"}:      k = 6'd3;
            {4'd4, 32'd0, "rahc"}:      k = 6'd4;
            {4'd8, "eunitnoc"}:         k = 6'd5;
            {4'd2, 48'd0, "od"}:        k = 6'd6;
            {4'd6, 16'd0, "elbuod"}:    k = 6'd7;
            {4'd4, 32'd0, "esle"}:      k = 6'd8;
            {4'd4, 32'd0, "mune"}:      k = 6'd9;
            {4'd6, 16'd0, "nretxe"}:    k = 6'd10;
            {4'd5, 24'd0, "taolf"}:     k = 6'd11;
            {4'd3, 40'd0, "rof"}:       k = 6'd12;
            {4'd2, 48'd0, "fi"}:        k = 6'd13;
            {4'd3, 40'd0, "tni"}:       k = 6'd14;
            {4'd6, 16'd0, "nruter"}:    k = 6'd15;
            {4'd6, 16'd0, "foezis"}:    k = 6'd16;
            {4'd6, 16'd0, "citats"}:    k = 6'd17;
            {4'd6, 16'd0, "tcurts"}:    k = 6'd18;
            {4'd6, 16'd0, "hctiws"}:    k = 6'd19;
            {4'd7, 8'd0, "fedepyt"}:    k = 6'd20;
            {4'd5, 24'd0, "noinu"}:     k = 6'd21;
            {4'd4, 32'd0, "diov"}:      k = 6'd22;
            {4'd5, 24'd0, "elihw"}:     k = 6'd23;
            default:                    k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

// ===== src/cts_lexer.sv =====
module cts_lexer #(
    parameter int OFFSET_BITS   = cts_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_CHARS = cts_pkg::KEYWORD_CHARS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output cts_pkg::token_group_t grp
);
    localparam int CW = $clog2(KEYWORD_CHARS + 2);
    localparam logic [OFFSET_BITS-1:0] OMAX = '1;
    localparam logic [OFFSET_BITS+16:0] CLIP_MAX = (OFFSET_BITS+17)'(65535);

    cts_pkg::mode_t            mode_reg, mode_next;
    logic [7:0]                held_reg, held_next;
    logic [OFFSET_BITS-1:0]    pos_reg, pos_next, begin_reg, begin_next;
    logic [KEYWORD_CHARS*8-1:0] word_reg, word_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      done_reg, done_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= cts_pkg::M_IDLE;
            held_reg  <= '0;
            pos_reg   <= '0;
            begin_reg <= '0;
            word_reg  <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else if (in_valid && !done_reg) begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            word_reg  <= word_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // one extra bit so that a closing byte at the saturated position counts fully
    function automatic logic [15:0] clip(input logic [OFFSET_BITS:0] v);
        logic [OFFSET_BITS+16:0] w;
        w = {16'd0, v};
        return (w > CLIP_MAX) ? 16'hffff : w[15:0];
    endfunction

    function automatic logic [OFFSET_BITS:0] span(input logic [OFFSET_BITS-1:0] a,
                                                input logic [OFFSET_BITS:0] b);
        return (b >= {1'b0, a}) ? b - {1'b0, a} : '0;
    endfunction

    always_comb begin
        cts_pkg::token_t        t [8];
        logic [2:0]             n;
        logic [7:0]             c;
        logic [OFFSET_BITS-1:0] at, dot, ep;
        logic [OFFSET_BITS:0]   pe;
        logic                   cont, zero;
        logic [5:0]             k, kw;
        cts_pkg::mode_t         fm;
        logic [63:0]            w8;
        for (int i = 0; i < 8; i++) t[i] = '0;
        n = '0;
        c = in_byte;
        at = pos_reg;
        mode_next = mode_reg;
        held_next = held_reg;
        pos_next = pos_reg;
        begin_next = begin_reg;
        word_next = word_reg;
        cnt_next = cnt_reg;
        done_next = done_reg;
        cont = 1'b0;
        zero = (c == 8'd0);
        pe = {1'b0, at} + 1'b1;
        ep = (pos_reg != OMAX) ? pos_reg + 1'b1 : pos_reg;
        dot = (at != '0) ? at - 1'b1 : '0;
        k = '0;
        w8 = word_reg[63:0];
        kw = (cnt_reg <= CW'(KEYWORD_CHARS) && cnt_reg <= 4'd8)
           ? cts_pkg::keyword(w8, 4'(cnt_reg)) : cts_pkg::K_IDENT;
        fm = mode_reg;
        // continuation of the current token
        if (!zero) begin
            unique case (mode_reg)
                cts_pkg::M_IDENT: if (cts_pkg::is_alpha(c) || cts_pkg::is_digit(c)) begin
                    cont = 1'b1;
                    for (int i = 0; i < KEYWORD_CHARS; i++)
                        if (cnt_reg == CW'(i)) word_next[i*8 +: 8] = c;
                    if (cnt_reg <= CW'(KEYWORD_CHARS)) cnt_next = cnt_reg + 1'b1;
                end
                cts_pkg::M_INT: if (cts_pkg::is_digit(c)) cont = 1'b1;
                    else if (c == ".") begin cont = 1'b1; mode_next = cts_pkg::M_DOT; end
                cts_pkg::M_DOT: if (cts_pkg::is_digit(c)) begin
                    cont = 1'b1; mode_next = cts_pkg::M_FRAC;
                end
                cts_pkg::M_FRAC: if (cts_pkg::is_digit(c)) cont = 1'b1;
                cts_pkg::M_CHAR, cts_pkg::M_STR: begin
                    cont = 1'b1;
                    if ((mode_reg == cts_pkg::M_CHAR && c == "'") ||
                        (mode_reg == cts_pkg::M_STR && c == "\"")) begin
                        t[n] = '{mode_reg == cts_pkg::M_CHAR ? cts_pkg::K_CHARLIT
                                 : cts_pkg::K_STRLIT, clip({1'b0, begin_reg}),
                                 clip(span(begin_reg, pe))};
                        n = n + 1'b1;
                        mode_next = cts_pkg::M_IDLE;
                    end
                end
                cts_pkg::M_OP: begin
                    k = cts_pkg::pair_op(held_reg, c);
                    if (held_reg == "/" && c == "/") begin
                        cont = 1'b1; mode_next = cts_pkg::M_LINE;
                    end else if (held_reg == "/" && c == "*") begin
                        cont = 1'b1; mode_next = cts_pkg::M_BLOCK;
                    end else if (k != 6'd0) begin
                        cont = 1'b1;
                        t[n] = '{k, clip({1'b0, begin_reg}), clip(span(begin_reg, pe))};
                        n = n + 1'b1;
                        mode_next = cts_pkg::M_IDLE;
                    end
                end
                cts_pkg::M_LINE: begin
                    cont = 1'b1;
                    if (c == 8'h0a) mode_next = cts_pkg::M_IDLE;
                end
                cts_pkg::M_BLOCK: begin
                    cont = 1'b1;
                    if (c == "*") mode_next = cts_pkg::M_BSTAR;
                end
                cts_pkg::M_BSTAR: begin
                    cont = 1'b1;
                    if (c == "/") mode_next = cts_pkg::M_IDLE;
                    else if (c != "*") mode_next = cts_pkg::M_BLOCK;
                end
                default: cont = 1'b0;
            endcase
        end
        // flush of a pending token ending before at, either from a break or a zero byte
        if (zero || !cont) begin
            unique case (fm)
                cts_pkg::M_IDENT: begin
                    t[n] = '{kw, clip({1'b0, begin_reg}), clip(span(begin_reg, {1'b0, at}))};
                    n = n + 1'b1;
                end
                cts_pkg::M_INT, cts_pkg::M_FRAC: begin
                    t[n] = '{cts_pkg::K_NUM, clip({1'b0, begin_reg}),
                             clip(span(begin_reg, {1'b0, at}))};
                    n = n + 1'b1;
                end
                cts_pkg::M_DOT: begin
                    t[n] = '{cts_pkg::K_NUM, clip({1'b0, begin_reg}),
                             clip(span(begin_reg, {1'b0, dot}))};
                    t[n+1'b1] = '{cts_pkg::K_DOT, clip({1'b0, dot}), 16'd1};
                    n = n + 2'd2;
                end
                cts_pkg::M_CHAR: begin
                    t[n] = '{cts_pkg::K_CHARLIT, clip({1'b0, begin_reg}),
                             clip(span(begin_reg, {1'b0, at}))};
                    n = n + 1'b1;
                end
                cts_pkg::M_STR: begin
                    t[n] = '{cts_pkg::K_STRLIT, clip({1'b0, begin_reg}),
                             clip(span(begin_reg, {1'b0, at}))};
                    n = n + 1'b1;
                end
                cts_pkg::M_OP: begin
                    t[n] = '{cts_pkg::single_op(held_reg), clip({1'b0, begin_reg}), 16'd1};
                    n = n + 1'b1;
                end
                default: ;
            endcase
            mode_next = cts_pkg::M_IDLE;
        end
        if (zero) begin
            t[n] = '{cts_pkg::K_END, clip({1'b0, at}), 16'd0};
            n = n + 1'b1;
            done_next = 1'b1;
        end else begin
            if (!cont) begin
                if (!(c == 8'h20 || c == 8'h0d || c == 8'h09 || c == 8'h0a)) begin
                    begin_next = at;
                    if (cts_pkg::is_alpha(c)) begin
                        word_next = '0;
                        word_next[7:0] = c;
                        cnt_next = CW'(1);
                        mode_next = cts_pkg::M_IDENT;
                    end else if (cts_pkg::is_digit(c)) begin
                        mode_next = cts_pkg::M_INT;
                    end else if (c == "'") begin
                        mode_next = cts_pkg::M_CHAR;
                    end else if (c == "\"") begin
                        mode_next = cts_pkg::M_STR;
                    end else if (cts_pkg::single_op(c) != cts_pkg::K_ERROR) begin
                        held_next = c;
                        mode_next = cts_pkg::M_OP;
                    end else begin
                        t[n] = '{cts_pkg::punct(c), clip({1'b0, at}), 16'd1};
                        n = n + 1'b1;
                    end
                end
            end
            pos_next = ep;
            if (in_last) begin
                // flush at the new position, then end
                unique case (mode_next)
                    cts_pkg::M_IDENT: begin
                        t[n] = '{(cnt_next <= CW'(KEYWORD_CHARS))
                                 ? cts_pkg::keyword(word_next[63:0], 4'(cnt_next))
                                 : cts_pkg::K_IDENT,
                                 clip({1'b0, begin_next}), clip(span(begin_next, {1'b0, ep}))};
                        n = n + 1'b1;
                    end
                    cts_pkg::M_INT, cts_pkg::M_FRAC: begin
                        t[n] = '{cts_pkg::K_NUM, clip({1'b0, begin_next}),
                                 clip(span(begin_next, {1'b0, ep}))};
                        n = n + 1'b1;
                    end
                    cts_pkg::M_DOT: begin
                        t[n] = '{cts_pkg::K_NUM, clip({1'b0, begin_next}),
                                 clip(span(begin_next, {1'b0, ep - 1'b1}))};
                        t[n+1'b1] = '{cts_pkg::K_DOT, clip({1'b0, ep - 1'b1}), 16'd1};
                        n = n + 2'd2;
                    end
                    cts_pkg::M_CHAR: begin
                        t[n] = '{cts_pkg::K_CHARLIT, clip({1'b0, begin_next}),
                                 clip(span(begin_next, {1'b0, ep}))};
                        n = n + 1'b1;
                    end
                    cts_pkg::M_STR: begin
                        t[n] = '{cts_pkg::K_STRLIT, clip({1'b0, begin_next}),
                                 clip(span(begin_next, {1'b0, ep}))};
                        n = n + 1'b1;
                    end
                    cts_pkg::M_OP: begin
                        t[n] = '{cts_pkg::single_op(held_next), clip({1'b0, begin_next}),
                                 16'd1};
                        n = n + 1'b1;
                    end
                    default: ;
                endcase
                t[n] = '{cts_pkg::K_END, clip({1'b0, ep}), 16'd0};
                n = n + 1'b1;
                mode_next = cts_pkg::M_IDLE;
                done_next = 1'b1;
            end
        end
        if (done_reg) n = '0;
        grp.count = n;
        for (int i = 0; i < 4; i++) grp.tok[i] = t[i];
    end
endmodule

// ===== src/cts_out_queue.sv =====
module cts_out_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  cts_pkg::token_group_t grp,
    output logic                  busy,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cts_pkg::token_t       m_tok,
    output logic                  m_last
);
    cts_pkg::token_group_t g_reg;
    logic [2:0]            idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_reg.count <= '0;
            idx_reg     <= '0;
        end else if (load) begin
            g_reg   <= grp;
            idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign m_valid = idx_reg < g_reg.count;
    assign m_tok   = g_reg.tok[idx_reg[1:0]];
    assign m_last  = (idx_reg + 1'b1) == g_reg.count;
    // can take the next group when empty or on the final transfer
    assign busy    = m_valid && !(m_ready && m_last);
endmodule

// ===== src/c_token_scanner_top.sv =====
// C token scanner: one source byte per cycle in, tokens (kind, offset, length) out.
// A byte is taken in every cycle while the result side keeps up; a byte that
// produces several tokens (up to four) holds the input while the result register
// drains them, one token per transfer.
// A zero byte or s_axis_tlast ends the source; later bytes are taken and dropped
// until reset.
`include "c_token_scanner_top_assert.svh"
module c_token_scanner_top #(
    parameter int OFFSET_BITS   = cts_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_CHARS = cts_pkg::KEYWORD_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // source_byte
    input  logic        s_axis_tlast,   // end_of_source
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // token_kind, token_offset, token_length, zero pad
    output logic        m_axis_tlast    // last_of_run
);
    cts_pkg::token_group_t grp;
    cts_pkg::token_t       tok;
    logic                  busy, acc;

    assign s_axis_tready = !busy;
    assign acc = s_axis_tvalid && s_axis_tready;

    cts_lexer #(.OFFSET_BITS(OFFSET_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)) u_lex (
        .aclk, .aresetn, .in_valid(acc), .in_byte(s_axis_tdata),
        .in_last(s_axis_tlast), .grp
    );

    cts_out_queue u_q (
        .aclk, .aresetn, .load(acc), .grp, .busy,
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_tok(tok), .m_last(m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, tok.length, tok.offset, tok.kind};

    `CTS_ASSERT_IMPL(a_last_has_valid, aclk, aresetn, m_axis_tlast && m_axis_tvalid,
                     m_axis_tvalid)
    `CTS_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid)
    `CTS_ASSERT_IMPL(a_no_take_busy, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
                     !s_axis_tready)
endmodule

// ===== test/tb_c_token_scanner_top.sv =====
module tb_c_token_scanner_top;
    timeunit 1ns;
    timeprecision 1ps;

    class token_scoreboard;
        typedef struct {
            logic [5:0]  kind;
            logic [15:0] offset;
            logic [15:0] length;
            logic        last;
        } token_rec_t;

        token_rec_t     pending_tokens[$];
        int             errors;
        cts_pkg::mode_t mode;
        logic [7:0]     held_op;
        int unsigned    pos;
        int unsigned    tok_start;
        logic [7:0]     prefix[8];
        int             word_len;
        bit             done;
        string          keywords[23] = '{"bool", "break", "case", "char", "continue", "do",
            "double", "else", "enum", "extern", "float", "for", "if", "int", "return",
            "sizeof", "static", "struct", "switch", "typedef", "union", "void", "while"};

        function new();
            mode = cts_pkg::M_IDLE;
            held_op = 8'd0;
            pos = 0;
            tok_start = 0;
            word_len = 0;
            done = 0;
            errors = 0;
            foreach (prefix[i]) prefix[i] = 8'd0;
        endfunction

        function void push_token(logic [5:0] kind, int unsigned off, int unsigned len);
            token_rec_t t;
            t.kind = kind;
            t.offset = (off > 65535) ? 16'hffff : off[15:0];
            t.length = (len > 65535) ? 16'hffff : len[15:0];
            t.last = 1'b0;
            pending_tokens.push_back(t);
        endfunction

        function int unsigned dist_to(int unsigned from, int unsigned upto);
            return (upto >= from) ? upto - from : 0;
        endfunction

        function bit alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction

        function bit digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function logic [5:0] op_one(logic [7:0] h);
            case (h)
                "*": return 6'd37;
                "/": return 6'd39;
                "+": return 6'd41;
                "-": return 6'd44;
                ">": return 6'd48;
                "<": return 6'd50;
                "=": return 6'd52;
                "!": return 6'd54;
                default: return cts_pkg::K_ERROR;
            endcase
        endfunction

        // zero when the pair does not form an operator
        function logic [5:0] op_two(logic [7:0] h, logic [7:0] c);
            if (c == "=") begin
                case (h)
                    "*": return 6'd38;
                    "/": return 6'd40;
                    "+": return 6'd42;
                    "-": return 6'd45;
                    ">": return 6'd49;
                    "<": return 6'd51;
                    "=": return 6'd53;
                    "!": return 6'd55;
                    default: return 6'd0;
                endcase
            end
            if (h == "+" && c == "+") return 6'd43;
            if (h == "-" && c == "-") return 6'd46;
            if (h == "-" && c == ">") return 6'd47;
            return 6'd0;
        endfunction

        function void close_word(int unsigned upto);
            logic [5:0] kind;
            string w;
            kind = cts_pkg::K_IDENT;
            w = "";
            if (word_len <= 8) begin
                for (int i = 0; i < word_len; i++) w = {w, string'(prefix[i])};
                foreach (keywords[i]) if (keywords[i] == w) kind = 6'(i + 1);
            end
            push_token(kind, tok_start, dist_to(tok_start, upto));
        endfunction

        function void flush(int unsigned upto);
            int unsigned dot_at;
            case (mode)
                cts_pkg::M_IDENT: close_word(upto);
                cts_pkg::M_INT, cts_pkg::M_FRAC:
                    push_token(cts_pkg::K_NUM, tok_start, dist_to(tok_start, upto));
                cts_pkg::M_DOT: begin
                    dot_at = (upto > 0) ? upto - 1 : 0;
                    push_token(cts_pkg::K_NUM, tok_start, dist_to(tok_start, dot_at));
                    push_token(cts_pkg::K_DOT, dot_at, 1);
                end
                cts_pkg::M_CHAR:
                    push_token(cts_pkg::K_CHARLIT, tok_start, dist_to(tok_start, upto));
                cts_pkg::M_STR:
                    push_token(cts_pkg::K_STRLIT, tok_start, dist_to(tok_start, upto));
                cts_pkg::M_OP: push_token(op_one(held_op), tok_start, 1);
                default: ;
            endcase
            mode = cts_pkg::M_IDLE;
        endfunction

        function void open_token(logic [7:0] c, int unsigned at);
            logic [5:0] kind;
            mode = cts_pkg::M_IDLE;
            if (c == " " || c == 8'h0d || c == 8'h09 || c == 8'h0a) return;
            tok_start = at;
            if (alpha(c)) begin
                foreach (prefix[i]) prefix[i] = 8'd0;
                prefix[0] = c;
                word_len = 1;
                mode = cts_pkg::M_IDENT;
                return;
            end
            if (digit(c)) begin
                mode = cts_pkg::M_INT;
                return;
            end
            case (c)
                8'h27: begin mode = cts_pkg::M_CHAR; return; end
                8'h22: begin mode = cts_pkg::M_STR; return; end
                "*", "/", "+", "-", ">", "<", "=", "!": begin
                    held_op = c;
                    mode = cts_pkg::M_OP;
                    return;
                end
                "{": kind = 6'd27;
                "}": kind = 6'd28;
                "[": kind = 6'd29;
                "]": kind = 6'd30;
                "(": kind = 6'd31;
                ")": kind = 6'd32;
                "#": kind = 6'd33;
                ",": kind = 6'd34;
                ".": kind = 6'd35;
                ";": kind = 6'd36;
                default: kind = cts_pkg::K_ERROR;
            endcase
            push_token(kind, at, 1);
        endfunction

        function void advance(logic [7:0] c, int unsigned at);
            logic [5:0] kind;
            case (mode)
                cts_pkg::M_IDENT: if (alpha(c) || digit(c)) begin
                    if (word_len < 8) prefix[word_len] = c;
                    if (word_len <= 8) word_len++;
                    return;
                end
                cts_pkg::M_INT: begin
                    if (digit(c)) return;
                    if (c == ".") begin mode = cts_pkg::M_DOT; return; end
                end
                cts_pkg::M_DOT: if (digit(c)) begin mode = cts_pkg::M_FRAC; return; end
                cts_pkg::M_FRAC: if (digit(c)) return;
                cts_pkg::M_CHAR: begin
                    if (c == 8'h27) begin
                        push_token(cts_pkg::K_CHARLIT, tok_start, dist_to(tok_start, at + 1));
                        mode = cts_pkg::M_IDLE;
                    end
                    return;
                end
                cts_pkg::M_STR: begin
                    if (c == 8'h22) begin
                        push_token(cts_pkg::K_STRLIT, tok_start, dist_to(tok_start, at + 1));
                        mode = cts_pkg::M_IDLE;
                    end
                    return;
                end
                cts_pkg::M_OP: begin
                    if (held_op == "/" && c == "/") begin mode = cts_pkg::M_LINE; return; end
                    if (held_op == "/" && c == "*") begin mode = cts_pkg::M_BLOCK; return; end
                    kind = op_two(held_op, c);
                    if (kind != 6'd0) begin
                        push_token(kind, tok_start, dist_to(tok_start, at + 1));
                        mode = cts_pkg::M_IDLE;
                        return;
                    end
                end
                cts_pkg::M_LINE: begin
                    if (c == 8'h0a) mode = cts_pkg::M_IDLE;
                    return;
                end
                cts_pkg::M_BLOCK: begin
                    if (c == "*") mode = cts_pkg::M_BSTAR;
                    return;
                end
                cts_pkg::M_BSTAR: begin
                    if (c == "/") mode = cts_pkg::M_IDLE;
                    else if (c != "*") mode = cts_pkg::M_BLOCK;
                    return;
                end
                default: mode = cts_pkg::M_IDLE;
            endcase
            flush(at);
            open_token(c, at);
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            int first;
            if (done) return;
            first = pending_tokens.size();
            if (c == 8'd0) begin
                flush(pos);
                push_token(cts_pkg::K_END, pos, 0);
                done = 1;
            end else begin
                advance(c, pos);
                if (pos < 65535) pos++;
                if (last) begin
                    flush(pos);
                    push_token(cts_pkg::K_END, pos, 0);
                    done = 1;
                end
            end
            if (pending_tokens.size() > first)
                pending_tokens[pending_tokens.size() - 1].last = 1'b1;
        endfunction

        function void check_token(logic [39:0] data, logic last);
            token_rec_t exp_tok;
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token, actual kind %0d offset %0d length %0d",
                         $time, data[5:0], data[21:6], data[37:22]);
                errors++;
                return;
            end
            exp_tok = pending_tokens.pop_front();
            if (data[5:0] !== exp_tok.kind || data[21:6] !== exp_tok.offset ||
                data[37:22] !== exp_tok.length || last !== exp_tok.last) begin
                $display("%0t: token differs, expected kind %0d off %0d len %0d last %0b,",
                         $time, exp_tok.kind, exp_tok.offset, exp_tok.length, exp_tok.last);
                $display("    actual kind %0d off %0d len %0d last %0b",
                         data[5:0], data[21:6], data[37:22], last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    token_scoreboard scanner_sb = new();
    bit  sender_idles = 1;
    bit  receiver_idles = 1;
    bit  hold_request = 0;
    int  stall_cycles = 0;
    int  bytes_sent = 0;

    c_token_scanner_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            scanner_sb.note_byte(s_axis_tdata, s_axis_tlast);
        if (aresetn && m_axis_tvalid && m_axis_tready)
            scanner_sb.check_token(m_axis_tdata, m_axis_tlast);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 4000) begin
            $display("c_token_scanner_top: mismatch");
            $finish;
        end
    end

    initial begin
        int hold_left;
        m_axis_tready = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request && hold_left == 0) begin
                hold_left = 300;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(receiver_idles && $urandom_range(99) < 23);
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        while (sender_idles && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    function automatic string random_chars(int n, bit alnum_only);
        string s;
        string pool;
        pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(pool[$urandom_range(alnum_only ? pool.len() - 1 : 61)])};
        return s;
    endfunction

    function automatic string random_fragment();
        string ops[19] = '{"*", "/", "+", "-", ">", "<", "=", "!", "*=", "/=", "+=", "++",
                           "-=", "--", "->", ">=", "<=", "==", "!="};
        string puncts = "{}[]()#,.;";
        string s;
        case ($urandom_range(11))
            0, 1: s = scanner_sb.keywords[$urandom_range(22)];
            2: s = {random_chars(1, 0).substr(0, 0) == "0" ? "q" : "", "v",
                    random_chars($urandom_range(0, 11), 1)};
            3: begin
                s = $sformatf("%0d", $urandom_range(99999));
                case ($urandom_range(3))
                    0: s = {s, ".", $sformatf("%0d", $urandom_range(999))};
                    1: s = {s, "."};
                    default: ;
                endcase
            end
            4: s = {"'", random_chars($urandom_range(0, 2), 1), "'"};
            5: s = {"\"", random_chars($urandom_range(0, 6), 1), " \""};
            6: s = ops[$urandom_range(18)];
            7: s = string'(puncts[$urandom_range(9)]);
            8: s = {"// ", random_chars($urandom_range(0, 5), 1), "\n"};
            9: s = {"/* ", random_chars($urandom_range(0, 5), 1), " **/"};
            10: s = string'(8'($urandom_range(1, 255)));
            default: s = random_chars($urandom_range(1, 3), 1);
        endcase
        case ($urandom_range(5))
            0: s = {s, " "};
            1: s = {s, "\t"};
            2: s = {s, "\r\n"};
            default: ;
        endcase
        return s;
    endfunction

    initial begin
        bit hold_done;
        bit drain_done;
        hold_done = 0;
        drain_done = 0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        s_axis_tlast = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // keywords incl. the short ones, long names, number/dot, literals, ops
        send_text("do if double continue continues typedef abcdefghijk 9.5 3.x 1.;");
        send_text("'a' \"s\"{}[]()#,->>=<=!=*=/=++--==~@ /*c*/x//l\n");
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);

        while (bytes_sent < 395) begin
            sender_idles = !(bytes_sent > 250 && bytes_sent < 330);
            receiver_idles = sender_idles;
            if (!hold_done && bytes_sent > 150) begin
                hold_request = 1;
                hold_done = 1;
            end
            if (!drain_done && bytes_sent > 370) begin
                drain_done = 1;
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                while (scanner_sb.pending_tokens.size() != 0) @(posedge aclk);
            end
            send_text(random_fragment());
        end

        sender_idles = 1;
        receiver_idles = 1;
        // unterminated string closed by the last flag
        send_text("\"tai");
        send_byte("l", 1'b1);
        // ignored after the end of source
        send_byte(8'd0, 1'b1);
        send_byte("a", 1'b0);
        s_axis_tvalid <= 1'b0;

        while (scanner_sb.pending_tokens.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (scanner_sb.errors == 0 && scanner_sb.pending_tokens.size() == 0)
            $display("c_token_scanner_top: match");
        else
            $display("c_token_scanner_top: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/cts_pkg.sv
src/cts_lexer.sv
src/cts_out_queue.sv
src/c_token_scanner_top.sv
test/tb_c_token_scanner_top.sv
